// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the character display sequencer.
// Synthesis builds see empty macro bodies; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/clcd_pkg.sv =====
// Types and constants of the character display nibble sequencer.
// Used by the microcode ROM, the datapath and the top level; no dependencies.
package clcd_pkg;

	// Request codes.
	localparam logic [1:0] CMD_INIT   = 2'd0;
	localparam logic [1:0] CMD_ERASE  = 2'd1;
	localparam logic [1:0] CMD_CURSOR = 2'd2;
	localparam logic [1:0] CMD_PRINT  = 2'd3;

	// Program counter width and entry points of each routine.
	localparam int unsigned PC_W = 5;
	localparam logic [PC_W-1:0] ENTRY_INIT   = 5'd0;
	localparam logic [PC_W-1:0] ENTRY_CLEAR  = 5'd16;
	localparam logic [PC_W-1:0] ENTRY_CURSOR = 5'd18;
	localparam logic [PC_W-1:0] ENTRY_PRINT  = 5'd20;

	// Address command bases.
	localparam logic [7:0] ROW0_BASE = 8'h80;
	localparam logic [7:0] ROW1_BASE = 8'hC0;

	// Where the nibble of a step comes from.
	typedef enum logic [1:0] {
		NSRC_CONST = 2'd0,
		NSRC_HI    = 2'd1,
		NSRC_LO    = 2'd2
	} nib_src_t;

	// Sequencing operation at the end of a step.
	typedef enum logic {
		SEQ_NEXT = 1'b0,
		SEQ_END  = 1'b1
	} seq_op_t;

	// One microcode control word.
	typedef struct packed {
		nib_src_t    nib_src;
		logic [3:0]  const_nib;
		logic        rs;
		logic [15:0] wait_before;
		logic [13:0] wait_after;
		seq_op_t     seq_op;
	} ctrl_word_t;

	// Input item.
	typedef struct packed {
		logic [1:0] cmd;
		logic       row;
		logic [5:0] col;
		logic [7:0] char_code;
	} lcd_req_t;

	// Result item.
	typedef struct packed {
		logic        reg_select;
		logic [3:0]  nibble;
		logic [15:0] wait_before_us;
		logic [13:0] wait_after_us;
		logic        last;
	} lcd_nib_t;

endpackage

// ===== sv/clcd_ucode_rom.sv =====
// Microcode ROM of the character display sequencer: one control word per step.
// Depends on clcd_pkg for the control word type and entry points.
module clcd_ucode_rom (
	input  logic [clcd_pkg::PC_W-1:0] pc,
	output clcd_pkg::ctrl_word_t      word
);

	// Builds one control word.
	function automatic clcd_pkg::ctrl_word_t mk(
		input clcd_pkg::nib_src_t src,
		input logic [3:0]         nib,
		input logic               rs,
		input logic [15:0]        pre_wait,
		input logic [13:0]        after,
		input clcd_pkg::seq_op_t  op
	);
		clcd_pkg::ctrl_word_t w;
		w.nib_src     = src;
		w.const_nib   = nib;
		w.rs          = rs;
		w.wait_before = pre_wait;
		w.wait_after  = after;
		w.seq_op      = op;
		return w;
	endfunction

	// Program: the power-up routine, then clear, cursor and print routines.
	always_comb begin
		unique case (pc)
			5'd0:  word = mk(clcd_pkg::NSRC_CONST, 4'h3, 1'b0, 16'd50000, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd1:  word = mk(clcd_pkg::NSRC_CONST, 4'h0, 1'b0, 16'd0, 14'd5000,
				clcd_pkg::SEQ_NEXT);
			5'd2:  word = mk(clcd_pkg::NSRC_CONST, 4'h3, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd3:  word = mk(clcd_pkg::NSRC_CONST, 4'h0, 1'b0, 16'd0, 14'd1000,
				clcd_pkg::SEQ_NEXT);
			5'd4:  word = mk(clcd_pkg::NSRC_CONST, 4'h3, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd5:  word = mk(clcd_pkg::NSRC_CONST, 4'h0, 1'b0, 16'd0, 14'd10000,
				clcd_pkg::SEQ_NEXT);
			5'd6:  word = mk(clcd_pkg::NSRC_CONST, 4'h2, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd7:  word = mk(clcd_pkg::NSRC_CONST, 4'h0, 1'b0, 16'd0, 14'd10000,
				clcd_pkg::SEQ_NEXT);
			5'd8:  word = mk(clcd_pkg::NSRC_CONST, 4'h2, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd9:  word = mk(clcd_pkg::NSRC_CONST, 4'h8, 1'b0, 16'd0, 14'd1000,
				clcd_pkg::SEQ_NEXT);
			5'd10: word = mk(clcd_pkg::NSRC_CONST, 4'h0, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd11: word = mk(clcd_pkg::NSRC_CONST, 4'h1, 1'b0, 16'd0, 14'd5000,
				clcd_pkg::SEQ_NEXT);
			5'd12: word = mk(clcd_pkg::NSRC_CONST, 4'h0, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd13: word = mk(clcd_pkg::NSRC_CONST, 4'h6, 1'b0, 16'd0, 14'd1000,
				clcd_pkg::SEQ_NEXT);
			5'd14: word = mk(clcd_pkg::NSRC_CONST, 4'h0, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd15: word = mk(clcd_pkg::NSRC_CONST, 4'hC, 1'b0, 16'd0, 14'd1000,
				clcd_pkg::SEQ_END);
			// Clear display.
			5'd16: word = mk(clcd_pkg::NSRC_CONST, 4'h0, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd17: word = mk(clcd_pkg::NSRC_CONST, 4'h1, 1'b0, 16'd0, 14'd2000,
				clcd_pkg::SEQ_END);
			// Set cursor address from the captured byte.
			5'd18: word = mk(clcd_pkg::NSRC_HI, 4'h0, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd19: word = mk(clcd_pkg::NSRC_LO, 4'h0, 1'b0, 16'd0, 14'd1000,
				clcd_pkg::SEQ_END);
			// Print the captured character as data.
			5'd20: word = mk(clcd_pkg::NSRC_HI, 4'h0, 1'b1, 16'd0, 14'd0,
				clcd_pkg::SEQ_NEXT);
			5'd21: word = mk(clcd_pkg::NSRC_LO, 4'h0, 1'b1, 16'd0, 14'd1000,
				clcd_pkg::SEQ_END);
			default: word = mk(clcd_pkg::NSRC_CONST, 4'h0, 1'b0, 16'd0, 14'd0,
				clcd_pkg::SEQ_END);
		endcase
	end

endmodule

// ===== sv/clcd_datapath.sv =====
// Datapath of the character display sequencer: byte register and result register.
// Depends on clcd_pkg for the request, result and control word types.
module clcd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  clcd_pkg::lcd_req_t   request,
	input  logic                 emit,
	input  clcd_pkg::ctrl_word_t word,
	output logic                 strobe,
	output clcd_pkg::lcd_nib_t   result
);

	logic [7:0]         byte_q;
	logic [7:0]         byte_d;
	logic [3:0]         nib_d;
	clcd_pkg::lcd_nib_t result_q;
	logic               strobe_q;

	// The request byte: an address command for the cursor, else the character.
	always_comb begin
		if (request.cmd == clcd_pkg::CMD_CURSOR) begin
			byte_d = (request.row ? clcd_pkg::ROW1_BASE : clcd_pkg::ROW0_BASE)
				| {2'b00, request.col};
		end else begin
			byte_d = request.char_code;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
		end
	end

	// Nibble selection as the control word asks.
	always_comb begin
		unique case (word.nib_src)
			clcd_pkg::NSRC_HI: nib_d = byte_q[7:4];
			clcd_pkg::NSRC_LO: nib_d = byte_q[3:0];
			default:           nib_d = word.const_nib;
		endcase
	end

	// Result register; the strobe marks one transfer per emitted step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.reg_select     <= word.rs;
			result_q.nibble         <= nib_d;
			result_q.wait_before_us <= word.wait_before;
			result_q.wait_after_us  <= word.wait_after;
			result_q.last           <= (word.seq_op == clcd_pkg::SEQ_END);
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== sv/char_lcd_nibble_sequencer.sv =====
// Character display nibble sequencer: one request becomes a run of 4-bit transfers.
// Order: a taken request sets the run flag and program counter, and each running step then loads
// the result register and strobe; one nibble strobes per cycle during a run. Busy stays high while
// the step counter emits the nibbles (2, or 16 for init); a new request is taken only once busy is low.
// Reset: arst_n clears the run flag and the strobe at once; no item is in flight.
// Depends on clcd_pkg, clcd_ucode_rom, clcd_datapath and assert_macros.svh.
`include "assert_macros.svh"

module char_lcd_nibble_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  clcd_pkg::lcd_req_t request,
	output logic               strobe,
	output clcd_pkg::lcd_nib_t result
);

	logic [clcd_pkg::PC_W-1:0] pc_q;
	logic [clcd_pkg::PC_W-1:0] entry;
	logic                      run_q;
	logic                      accept;
	clcd_pkg::ctrl_word_t      word;

	assign accept = start && !run_q;
	assign busy   = run_q;

	// Dispatch: each request jumps to its routine.
	always_comb begin
		unique case (request.cmd)
			clcd_pkg::CMD_INIT:   entry = clcd_pkg::ENTRY_INIT;
			clcd_pkg::CMD_ERASE:  entry = clcd_pkg::ENTRY_CLEAR;
			clcd_pkg::CMD_CURSOR: entry = clcd_pkg::ENTRY_CURSOR;
			default:              entry = clcd_pkg::ENTRY_PRINT;
		endcase
	end

	// Step counter: advance each cycle, stop on the end-of-routine word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pc_q  <= '0;
		end else if (accept) begin
			run_q <= 1'b1;
			pc_q  <= entry;
		end else if (run_q) begin
			if (word.seq_op == clcd_pkg::SEQ_END) begin
				run_q <= 1'b0;
			end else begin
				pc_q <= pc_q + clcd_pkg::PC_W'(1);
			end
		end
	end

	clcd_ucode_rom u_rom (
		.pc   (pc_q),
		.word (word)
	);

	clcd_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.request (request),
		.emit    (run_q),
		.word    (word),
		.strobe  (strobe),
		.result  (result)
	);

	// A taken request starts a run, and every running cycle yields a transfer.
	`ASSERT_NEXT(a_accept_runs, clk, arst_n, start && !busy, busy)
	`ASSERT_NEXT(a_run_strobes, clk, arst_n, busy, strobe)
	// The final nibble appears only once the sequencer has gone idle.
	`ASSERT_SAME(a_last_idle, clk, arst_n, strobe && result.last, !busy)
	`ASSERT_SAME(a_mid_busy, clk, arst_n, strobe && !result.last, busy)

endmodule
